// ===== hdl/smr_pkg.sv =====
// ----------------------------------------------------------------------------
// smr_pkg: shared types and constants for the row softmax unit
// Sizes, the exponential factor table and datapath operation codes.
// ----------------------------------------------------------------------------
package smr_pkg;
    localparam int MaxRow = 64;
    localparam int ExpTableBits = 8;
    localparam int AddrW = $clog2(MaxRow);
    localparam int CntW = $clog2(MaxRow + 1);
    localparam logic [16:0] Log2eMul = 17'd94548;

    localparam logic [1:0] OpIdle = 2'd0;
    localparam logic [1:0] OpMul = 2'd1;

    typedef logic [AddrW-1:0] t_addr;
    typedef logic [CntW-1:0] t_cnt;

    function automatic logic [23:0] f_pow2_frac(input logic [3:0] b);
        logic [23:0] v;
        case (b)
            4'd1: v = 24'd11863283;
            4'd2: v = 24'd14107901;
            4'd3: v = 24'd15384775;
            4'd4: v = 24'd16065917;
            4'd5: v = 24'd16417715;
            4'd6: v = 24'd16596492;
            4'd7: v = 24'd16686609;
            4'd8: v = 24'd16731851;
            4'd9: v = 24'd16754518;
            4'd10: v = 24'd16765863;
            4'd11: v = 24'd16771539;
            4'd12: v = 24'd16774377;
            default: v = 24'd0;
        endcase
        return v;
    endfunction
endpackage

// ===== hdl/smr_ram.sv =====
// ----------------------------------------------------------------------------
// smr_ram: generic single port RAM
// One write and one read of the same address per cycle, registered read data.
// ----------------------------------------------------------------------------
module smr_ram #(
    parameter int Width = 16,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== hdl/smr_datapath.sv =====
// ----------------------------------------------------------------------------
// smr_datapath: shared multiply unit and divider
// One 24x24-class multiplier serves log2 scaling and the exp factor chain;
// a restoring divider makes one quotient bit a cycle.
// ----------------------------------------------------------------------------
module smr_datapath (
    input  logic        i_clk,
    input  logic [1:0]  i_op,      // idle or multiply a*b
    input  logic [24:0] i_a,
    input  logic [23:0] i_b,
    output logic [48:0] o_prod,
    input  logic        i_div_start,
    input  logic [15:0] i_div_num,
    input  logic [22:0] i_div_den,
    output logic        o_div_busy,
    output logic [15:0] o_div_q
);
    import smr_pkg::*;
    logic [48:0] r_prod;
    logic [5:0]  r_div_cnt;
    logic [38:0] r_rem;
    logic [32:0] r_q;
    logic [39:0] w_trial;

    assign o_prod = r_prod;
    always_ff @(posedge i_clk) begin
        if (i_op == OpMul) begin
            r_prod <= i_a * i_b;
        end
    end

    // numerator = e*65536 + den/2, 33 bits; 33 quotient bits one per cycle
    assign w_trial = {r_rem, r_q[32]} - {17'd0, i_div_den};
    always_ff @(posedge i_clk) begin
        if (i_div_start) begin
            r_q <= {1'b0, i_div_num, 16'd0} + {11'd0, i_div_den[22:1]};
            r_rem <= '0;
            r_div_cnt <= 6'd33;
        end else if (r_div_cnt != 6'd0) begin
            if (!w_trial[39]) begin
                r_rem <= w_trial[38:0];
                r_q <= {r_q[31:0], 1'b1};
            end else begin
                r_rem <= {r_rem[37:0], r_q[32]};
                r_q <= {r_q[31:0], 1'b0};
            end
            r_div_cnt <= r_div_cnt - 6'd1;
        end
    end
    assign o_div_busy = i_div_start || (r_div_cnt != 6'd0);
    assign o_div_q = (r_q[32:16] != 17'd0) ? 16'hFFFF : r_q[15:0];
endmodule

// ===== hdl/softmax_row_forward_unit.sv =====
// ----------------------------------------------------------------------------
// softmax_row_forward_unit: row softmax with maximum subtraction
// Collects a row of Q8.8 logits, then computes exp, sum and normalized
// probabilities with one shared multiplier and a bit-serial divider.
// ----------------------------------------------------------------------------
// channel | direction | handshake     | payload
// in      | input     | valid / stall | logit
// out     | output    | valid / stall | probability, row_end
// cfg     | input     | valid / ready | row_length
// Collect: one cycle per logit. Exp pass per element: a read, the log2e
// multiply, eight table steps with one multiply per set fraction bit and
// the exp write. Output per element: a read, a 33-step bit-serial divide
// and the result register. Reset is synchronous, active low; RAM contents
// are not cleared. Output stall holds the result register.
// ----------------------------------------------------------------------------
module softmax_row_forward_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_logit,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_probability,
    output logic        o_row_end,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_row_length
);
    import smr_pkg::*;

    localparam logic [3:0] S_FILL = 4'd0, S_XRD = 4'd1, S_XWT = 4'd2, S_MUL = 4'd3,
                           S_LOOP = 4'd4, S_FMUL = 4'd5, S_EXPW = 4'd6,
                           S_DRD = 4'd7, S_DWT = 4'd8, S_DIV = 4'd9, S_DWAIT = 4'd10,
                           S_OUT = 4'd11;

    logic [3:0]  r_state;
    logic [6:0]  r_row_length;
    logic signed [15:0] r_max;
    t_cnt        r_fill;
    t_cnt        r_idx;
    logic [22:0] r_sum;
    logic [3:0]  r_b;
    logic [24:0] r_m;
    logic [15:0] r_f;
    logic [8:0]  r_k;
    logic [15:0] r_prob;
    logic        r_last;
    logic        r_ovalid;
    logic [1:0]  w_op;
    logic [24:0] w_a;
    logic [23:0] w_b;
    logic [48:0] w_prod;
    logic        w_div_start, w_div_busy;
    logic [15:0] w_div_q;
    logic        lr_we, er_we;
    t_addr       lr_addr, er_addr;
    logic [15:0] lr_rdata, er_rdata, w_e;
    t_cnt        w_len;
    logic        w_acc;
    logic [16:0] w_x;
    logic [32:0] w_y;
    logic [48:0] w_round;
    logic [25:0] w_esh;

    assign w_len = (r_row_length == 7'd0) ? t_cnt'(1) :
                   (r_row_length > 7'(MaxRow)) ? t_cnt'(MaxRow) : t_cnt'(r_row_length);
    assign o_in_stall = (r_state != S_FILL);
    assign o_cfg_ready = 1'b1;
    assign w_acc = i_in_valid && !o_in_stall;
    assign o_out_valid = r_ovalid;
    assign o_probability = r_prob;
    assign o_row_end = r_last;

    assign lr_we = w_acc;
    assign lr_addr = w_acc ? t_addr'(r_fill) : t_addr'(r_idx);
    assign er_we = (r_state == S_EXPW);
    assign er_addr = t_addr'(r_idx);

    smr_ram #(.Width(16), .Depth(MaxRow)) u_lram (
        .i_clk(i_clk), .i_we(lr_we), .i_addr(lr_addr), .i_wdata(i_logit),
        .o_rdata(lr_rdata));
    smr_ram #(.Width(16), .Depth(MaxRow)) u_eram (
        .i_clk(i_clk), .i_we(er_we), .i_addr(er_addr), .i_wdata(w_e),
        .o_rdata(er_rdata));

    assign w_x = 17'(r_max) - 17'($signed(lr_rdata));
    always_comb begin
        w_op = OpIdle;
        w_a = '0;
        w_b = '0;
        if (r_state == S_XWT) begin
            w_op = OpMul;
            w_a = {9'd0, w_x[15:0]};
            w_b = {7'd0, Log2eMul};
        end else if (r_state == S_LOOP) begin
            w_op = OpMul;
            w_a = r_m;
            w_b = f_pow2_frac(r_b);
        end
    end
    assign w_y = w_prod[40:8];
    assign w_round = w_prod + 49'h800000;
    assign w_esh = (r_k > 9'd24) ? 26'd0 :
                   (26'(r_m) + (26'd1 << (r_k + 9'd7))) >> (r_k + 9'd8);
    assign w_e = (w_esh > 26'd65535) ? 16'hFFFF : w_esh[15:0];

    assign w_div_start = (r_state == S_DWT);
    smr_datapath u_dp (
        .i_clk(i_clk), .i_op(w_op), .i_a(w_a), .i_b(w_b), .o_prod(w_prod),
        .i_div_start(w_div_start), .i_div_num(er_rdata), .i_div_den(r_sum),
        .o_div_busy(w_div_busy), .o_div_q(w_div_q));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FILL;
            r_row_length <= 7'd64;
            r_max <= '0;
            r_fill <= '0;
            r_idx <= '0;
            r_sum <= '0;
            r_ovalid <= 1'b0;
            r_b <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_row_length <= i_cfg_row_length;
            end
            if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_FILL: begin
                    if (w_acc) begin
                        if (r_fill == '0 || $signed(i_logit) > r_max) begin
                            r_max <= $signed(i_logit);
                        end
                        r_fill <= r_fill + t_cnt'(1);
                        if (r_fill + t_cnt'(1) >= w_len) begin
                            r_state <= S_XRD;
                            r_idx <= '0;
                            r_sum <= '0;
                        end
                    end
                end
                S_XRD: r_state <= S_XWT;
                S_XWT: r_state <= S_MUL;
                S_MUL: begin
                    r_k <= (w_y[32:16] > 17'd255) ? 9'd255 : 9'(w_y[32:16]);
                    r_f <= w_y[15:0];
                    r_m <= 25'd1 << 24;
                    r_b <= 4'd1;
                    r_state <= S_LOOP;
                end
                S_LOOP: begin
                    if (r_b > 4'(ExpTableBits)) begin
                        r_state <= S_EXPW;
                    end else if (r_f[4'd15 - (r_b - 4'd1)]) begin
                        r_state <= S_FMUL;
                    end else begin
                        r_b <= r_b + 4'd1;
                    end
                end
                S_FMUL: begin
                    r_m <= w_round[48:24];
                    r_b <= r_b + 4'd1;
                    r_state <= S_LOOP;
                end
                S_EXPW: begin
                    r_sum <= r_sum + 23'(w_e);
                    if (r_idx + t_cnt'(1) >= r_fill) begin
                        r_idx <= '0;
                        r_state <= S_DRD;
                    end else begin
                        r_idx <= r_idx + t_cnt'(1);
                        r_state <= S_XRD;
                    end
                end
                S_DRD: begin
                    if (!r_ovalid || !i_out_stall) begin
                        r_state <= S_DWT;
                    end
                end
                S_DWT: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (!w_div_busy) begin
                        r_state <= S_DWAIT;
                    end
                end
                S_DWAIT: begin
                    if (!r_ovalid || !i_out_stall) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_prob <= (r_sum == '0) ? 16'd0 : w_div_q;
                    r_last <= (r_idx + t_cnt'(1) >= r_fill);
                    if (r_idx + t_cnt'(1) >= r_fill) begin
                        r_fill <= '0;
                        r_max <= '0;
                        r_state <= S_FILL;
                    end else begin
                        r_idx <= r_idx + t_cnt'(1);
                        r_state <= S_DRD;
                    end
                end
                default: r_state <= S_FILL;
            endcase
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_probability))
        else $error("result changed under stall");
    a_no_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_FILL |-> o_in_stall)
        else $error("input open while busy");
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= t_cnt'(MaxRow))
        else $error("fill count overflow");
endmodule
